@@ rtl/core/mnp_pkg.sv @@
// ----------------------------------------------------------------------------
// mnp_pkg: shared types, constants and helpers for the MIDI note parser
// Status byte codes, message kinds and the result record.
// ----------------------------------------------------------------------------
package mnp_pkg;

	localparam logic [7:0] REALTIME_MIN = 8'hF8;
	localparam logic [7:0] SYSTEM_MIN   = 8'hF0;
	localparam logic [7:0] NO_STATUS    = 8'h00;

	localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
	localparam logic [3:0] KIND_PROGRAM  = 4'hC;
	localparam logic [3:0] KIND_PRESSURE = 4'hD;

	localparam logic [1:0] LEN_SHORT = 2'd1;
	localparam logic [1:0] LEN_LONG  = 2'd2;

	typedef struct packed {
		logic [6:0] note_number;
		logic [6:0] note_velocity;
		logic       pressed;
	} note_t;

	typedef struct packed {
		logic  hit;
		note_t note;
	} parse_res_t;

	function automatic logic [1:0] msg_length(input logic [7:0] status);
		logic [3:0] kind;
		kind = status[7:4];
		return (kind == KIND_PROGRAM || kind == KIND_PRESSURE) ? LEN_SHORT : LEN_LONG;
	endfunction

	function automatic logic is_note(input logic [7:0] status);
		logic [3:0] kind;
		kind = status[7:4];
		return (kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON);
	endfunction

endpackage

@@ rtl/core/mnp_parse.sv @@
// ----------------------------------------------------------------------------
// mnp_parse: running-status tracker and note decoder
// Decodes the staged byte against the current state; state moves on take.
// ----------------------------------------------------------------------------
module mnp_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           byte_s1,
	input  logic                 pkt_end_s1,
	input  logic                 take,
	output mnp_pkg::parse_res_t  res
);

	logic [7:0] status_q, status_d;
	logic [1:0] pend_q, pend_d;
	logic [6:0] held_q, held_d;
	logic [1:0] pend_eff;

	always_comb begin
		status_d = status_q;
		pend_d   = pend_q;
		held_d   = held_q;
		pend_eff = pend_q;
		res.hit  = 1'b0;
		res.note.note_number   = held_q;
		res.note.note_velocity = byte_s1[6:0];
		res.note.pressed       = (status_q[7:4] == mnp_pkg::KIND_NOTE_ON) &&
		                         (byte_s1[6:0] != 7'd0);
		if (byte_s1 >= mnp_pkg::REALTIME_MIN) begin
			// realtime: nothing changes
		end else if (byte_s1[7]) begin
			if (byte_s1 < mnp_pkg::SYSTEM_MIN) begin
				status_d = byte_s1;
				pend_d   = mnp_pkg::msg_length(byte_s1);
			end else begin
				status_d = mnp_pkg::NO_STATUS;
				pend_d   = 2'd0;
			end
		end else if (status_q != mnp_pkg::NO_STATUS) begin
			// data byte with nothing pending reopens a message of the running type
			pend_eff = (pend_q == 2'd0) ? mnp_pkg::msg_length(status_q) : pend_q;
			if (mnp_pkg::is_note(status_q)) begin
				if (pend_eff >= mnp_pkg::LEN_LONG) begin
					held_d = byte_s1[6:0];
					pend_d = mnp_pkg::LEN_SHORT;
				end else begin
					res.hit = 1'b1;
					pend_d  = 2'd0;
				end
			end else begin
				pend_d = pend_eff - 2'd1;
			end
		end
		if (pkt_end_s1) begin
			status_d = mnp_pkg::NO_STATUS;
			pend_d   = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= mnp_pkg::NO_STATUS;
			pend_q   <= 2'd0;
		end else if (take) begin
			status_q <= status_d;
			pend_q   <= pend_d;
		end
	end

	// held byte is only read after a first data byte wrote it
	always_ff @(posedge clk) begin
		if (take) begin
			held_q <= held_d;
		end
	end

endmodule

@@ rtl/core/mnp_outreg.sv @@
// ----------------------------------------------------------------------------
// mnp_outreg: result register for decoded note beats
// Holds one note until the consumer takes it.
// ----------------------------------------------------------------------------
module mnp_outreg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  mnp_pkg::note_t note_d,
	input  logic           note_stall,
	output logic           free,
	output logic           note_valid,
	output mnp_pkg::note_t note_q
);

	logic valid_q;

	assign free       = !valid_q || !note_stall;
	assign note_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			note_q <= note_d;
		end
	end

endmodule

@@ rtl/core/midi_note_event_parser_core.sv @@
// ----------------------------------------------------------------------------
// midi_note_event_parser_core: MIDI running-status note parser
//
//   channel | beat carries                          | handshake
//   --------+---------------------------------------+-----------------------
//   byte    | in_byte[7:0], packet_end              | byte_valid / byte_stall
//   note    | note_number, note_velocity, pressed   | note_valid / note_stall
//
// One byte per cycle while byte_stall is low. A byte is decoded in the input
// stage register; a completed note then goes into the note port's register.
// Reset clears the running status, the pending count and both valid flags.
// byte_stall rises only when a note is ready and the output register still
// holds an untaken note; bytes that complete no note are never held up.
// ----------------------------------------------------------------------------
module midi_note_event_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] in_byte,
	input  logic       packet_end,
	output logic       note_valid,
	input  logic       note_stall,
	output logic [6:0] note_number,
	output logic [6:0] note_velocity,
	output logic       pressed
);

	logic                vld_s1;
	logic [7:0]          byte_s1;
	logic                pkt_end_s1;
	logic                take;
	logic                load;
	logic                out_free;
	mnp_pkg::parse_res_t res;
	mnp_pkg::note_t      note_q;

	assign byte_stall = vld_s1 && res.hit && !out_free;
	assign take       = vld_s1 && !byte_stall;
	assign load       = vld_s1 && res.hit && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!byte_stall) begin
			vld_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1    <= in_byte;
			pkt_end_s1 <= packet_end;
		end
	end

	mnp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_s1    (byte_s1),
		.pkt_end_s1 (pkt_end_s1),
		.take       (take),
		.res        (res)
	);

	mnp_outreg u_outreg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.note_d     (res.note),
		.note_stall (note_stall),
		.free       (out_free),
		.note_valid (note_valid),
		.note_q     (note_q)
	);

	assign note_number   = note_q.note_number;
	assign note_velocity = note_q.note_velocity;
	assign pressed       = note_q.pressed;

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> vld_s1)
		else $error("byte stall with empty input stage");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(note_valid && note_stall) |-> !load)
		else $error("held note overwritten");

	a_note_from_data: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !byte_s1[7])
		else $error("note completed by a status byte");

	a_pressed_vel: assert property (@(posedge clk) disable iff (!arst_n)
		(note_valid && pressed) |-> (note_velocity != 7'd0))
		else $error("pressed with zero velocity");
`endif

endmodule
